// File: src/tsc_pkg.sv
// shared constants, register map and types for the touch sample calibration block
`default_nettype none

package tsc_pkg;

    // screen size in pixels
    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 240;

    // raw conversion full scale
    localparam int          RAW_W      = 12;
    localparam logic [12:0] FULL_SCALE = 13'd4095;

    // field widths
    localparam int PRES_W   = 13;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int ORIENT_W = 3;

    // divider sizing: |raw diff| * (size - 1) fits in RAW_W + clog2(size) bits
    localparam int DIM_W  = $clog2((SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H);
    localparam int NUM_W  = RAW_W + DIM_W;
    localparam int SPAN_W = RAW_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // register map, index = paddr / 4
    localparam int ADDR_W  = 5;
    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PRESSURE_MIN = 3'd0,
        REG_RAW_MIN_X    = 3'd1,
        REG_RAW_MAX_X    = 3'd2,
        REG_RAW_MIN_Y    = 3'd3,
        REG_RAW_MAX_Y    = 3'd4,
        REG_ORIENT_FLAGS = 3'd5,
        REG_ZONE_TOP_ROW = 3'd6,
        REG_SPLIT_COLUMN = 3'd7
    } reg_idx_t;

    // orientation flag bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: src/touch_sample_calibrate_zone_unit.sv
// top level: pressure check, axis calibration, clamping and button zone decode
//
// One sample is taken at a time. Its result is computed by the two restoring
// dividers, one per axis, which run side by side and produce one quotient bit
// per cycle. A finished result sits in the output register until taken; the
// next sample is accepted while it waits. The held screen position changes
// only on a valid touch and is reported with every result. Registers are
// written over the APB port; the user must write them only while the block
// is idle, as the block itself has no check that enforces this.
`default_nettype none

module touch_sample_calibrate_zone_unit (
    input  wire         clk,
    input  wire         rst_n,
    // apb configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample input: z1_reading[11:0], z2_reading[23:12], raw_x[35:24], raw_y[47:36]
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [47:0]  s_tdata,
    // result: screen_x[8:0], screen_y[16:9], pressure[29:17], button_a[30], button_b[31]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,
    // result flag: touched[0]
    output logic        m_tuser
);
    import tsc_pkg::*;

    // configuration registers
    logic [PRES_W-1:0]   pressure_min_reg;
    logic [RAW_W-1:0]    raw_min_x_reg;
    logic [RAW_W-1:0]    raw_max_x_reg;
    logic [RAW_W-1:0]    raw_min_y_reg;
    logic [RAW_W-1:0]    raw_max_y_reg;
    logic [ORIENT_W-1:0] orient_flags_reg;
    logic [ROW_W-1:0]    zone_top_row_reg;
    logic [COL_W-1:0]    split_column_reg;
    logic                cfg_write;
    reg_idx_t            cfg_idx;

    // sequencer and sample registers
    state_t              state_reg;
    state_t              state_next;
    logic [RAW_W-1:0]    raw_x_reg;
    logic [RAW_W-1:0]    raw_y_reg;
    logic [PRES_W-1:0]   pressure_reg;
    logic                touch_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic                zero_x_reg;
    logic                zero_y_reg;

    // output registers
    logic                out_valid_reg;
    logic                out_touch_reg;
    logic [PRES_W-1:0]   out_pressure_reg;
    logic                out_a_reg;
    logic                out_b_reg;
    logic [COL_W-1:0]    held_col_reg;
    logic [ROW_W-1:0]    held_row_reg;

    // combinational helpers
    logic [RAW_W-1:0]    z1_in;
    logic [RAW_W-1:0]    z2_in;
    logic [RAW_W-1:0]    rx_in;
    logic [RAW_W-1:0]    ry_in;
    logic [PRES_W-1:0]   pressure_in;
    logic                touch_in;
    logic                accept;
    logic                out_free;
    logic [RAW_W-1:0]    ax;
    logic [RAW_W-1:0]    ay;
    logic [RAW_W:0]      dx;
    logic [RAW_W:0]      dy;
    logic [RAW_W:0]      span_x;
    logic [RAW_W:0]      span_y;
    logic [RAW_W:0]      dx_abs;
    logic [RAW_W:0]      dy_abs;
    logic [RAW_W:0]      span_x_abs;
    logic [RAW_W:0]      span_y_abs;
    logic [NUM_W-1:0]    num_x;
    logic [NUM_W-1:0]    num_y;
    logic                div_start;
    logic                busy_x;
    logic                busy_y;
    logic [NUM_W-1:0]    quo_x;
    logic [NUM_W-1:0]    quo_y;
    logic [NUM_W-1:0]    cal_x;
    logic [NUM_W-1:0]    cal_y;
    logic [NUM_W-1:0]    fin_x;
    logic [NUM_W-1:0]    fin_y;
    logic [COL_W-1:0]    col_new;
    logic [ROW_W-1:0]    row_new;
    logic                in_zone;

    // apb access
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_min_reg <= PRES_W'(400);
            raw_min_x_reg    <= RAW_W'(200);
            raw_max_x_reg    <= RAW_W'(3900);
            raw_min_y_reg    <= RAW_W'(200);
            raw_max_y_reg    <= RAW_W'(3900);
            orient_flags_reg <= '0;
            zone_top_row_reg <= ROW_W'(120);
            split_column_reg <= COL_W'(160);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PRESSURE_MIN: pressure_min_reg <= pwdata[PRES_W-1:0];
                REG_RAW_MIN_X:    raw_min_x_reg    <= pwdata[RAW_W-1:0];
                REG_RAW_MAX_X:    raw_max_x_reg    <= pwdata[RAW_W-1:0];
                REG_RAW_MIN_Y:    raw_min_y_reg    <= pwdata[RAW_W-1:0];
                REG_RAW_MAX_Y:    raw_max_y_reg    <= pwdata[RAW_W-1:0];
                REG_ORIENT_FLAGS: orient_flags_reg <= pwdata[ORIENT_W-1:0];
                REG_ZONE_TOP_ROW: zone_top_row_reg <= pwdata[ROW_W-1:0];
                REG_SPLIT_COLUMN: split_column_reg <= pwdata[COL_W-1:0];
                default:          ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            REG_PRESSURE_MIN: prdata = 32'(pressure_min_reg);
            REG_RAW_MIN_X:    prdata = 32'(raw_min_x_reg);
            REG_RAW_MAX_X:    prdata = 32'(raw_max_x_reg);
            REG_RAW_MIN_Y:    prdata = 32'(raw_min_y_reg);
            REG_RAW_MAX_Y:    prdata = 32'(raw_max_y_reg);
            REG_ORIENT_FLAGS: prdata = 32'(orient_flags_reg);
            REG_ZONE_TOP_ROW: prdata = 32'(zone_top_row_reg);
            REG_SPLIT_COLUMN: prdata = 32'(split_column_reg);
            default:          prdata = '0;
        endcase
    end

    // input unpack, pressure and touch decision
    assign z1_in       = s_tdata[11:0];
    assign z2_in       = s_tdata[23:12];
    assign rx_in       = s_tdata[35:24];
    assign ry_in       = s_tdata[47:36];
    assign pressure_in = {1'b0, z1_in} + FULL_SCALE - {1'b0, z2_in};
    assign touch_in    = (pressure_in >= pressure_min_reg) && (rx_in != '0) && (ry_in != '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // axis swap, offsets and spans as sign and magnitude
    always_comb
    begin
        ax         = orient_flags_reg[ORIENT_SWAP] ? raw_y_reg : raw_x_reg;
        ay         = orient_flags_reg[ORIENT_SWAP] ? raw_x_reg : raw_y_reg;
        dx         = {1'b0, ax} - {1'b0, raw_min_x_reg};
        dy         = {1'b0, ay} - {1'b0, raw_min_y_reg};
        span_x     = {1'b0, raw_max_x_reg} - {1'b0, raw_min_x_reg};
        span_y     = {1'b0, raw_max_y_reg} - {1'b0, raw_min_y_reg};
        dx_abs     = dx[RAW_W] ? -dx : dx;
        dy_abs     = dy[RAW_W] ? -dy : dy;
        span_x_abs = span_x[RAW_W] ? -span_x : span_x;
        span_y_abs = span_y[RAW_W] ? -span_y : span_y;
        num_x      = NUM_W'(dx_abs[RAW_W-1:0]) * NUM_W'(SCREEN_W - 1);
        num_y      = NUM_W'(dy_abs[RAW_W-1:0]) * NUM_W'(SCREEN_H - 1);
    end

    assign div_start = (state_reg == ST_PREP);

    tsc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_x),
        .divisor  (span_x_abs[SPAN_W-1:0]),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    tsc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_y),
        .divisor  (span_y_abs[SPAN_W-1:0]),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // clamp, invert and zone decode
    always_comb
    begin
        if (zero_x_reg || neg_x_reg)
            cal_x = '0;
        else if (quo_x > NUM_W'(SCREEN_W - 1))
            cal_x = NUM_W'(SCREEN_W - 1);
        else
            cal_x = quo_x;
        if (zero_y_reg || neg_y_reg)
            cal_y = '0;
        else if (quo_y > NUM_W'(SCREEN_H - 1))
            cal_y = NUM_W'(SCREEN_H - 1);
        else
            cal_y = quo_y;
        fin_x   = orient_flags_reg[ORIENT_INV_X] ? NUM_W'(SCREEN_W - 1) - cal_x : cal_x;
        fin_y   = orient_flags_reg[ORIENT_INV_Y] ? NUM_W'(SCREEN_H - 1) - cal_y : cal_y;
        col_new = fin_x[COL_W-1:0];
        row_new = fin_y[ROW_W-1:0];
        in_zone = (row_new >= zone_top_row_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (!busy_x && !busy_y) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sample capture and sign flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_x_reg    <= rx_in;
            raw_y_reg    <= ry_in;
            pressure_reg <= pressure_in;
            touch_reg    <= touch_in;
        end
        if (div_start)
        begin
            neg_x_reg  <= dx[RAW_W] ^ span_x[RAW_W];
            neg_y_reg  <= dy[RAW_W] ^ span_y[RAW_W];
            zero_x_reg <= (span_x == '0);
            zero_y_reg <= (span_y == '0);
        end
    end

    // output register and held position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_col_reg  <= '0;
            held_row_reg  <= '0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
            if (touch_reg)
            begin
                held_col_reg <= col_new;
                held_row_reg <= row_new;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_touch_reg    <= touch_reg;
            out_pressure_reg <= pressure_reg;
            out_a_reg        <= touch_reg && in_zone && (col_new < split_column_reg);
            out_b_reg        <= touch_reg && in_zone && !(col_new < split_column_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_touch_reg;
    assign m_tdata  = {out_b_reg, out_a_reg, out_pressure_reg, held_row_reg, held_col_reg};

endmodule

`default_nettype wire

// File: src/tsc_div.sv
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module tsc_div (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire [tsc_pkg::NUM_W-1:0]  dividend,
    input  wire [tsc_pkg::SPAN_W-1:0] divisor,
    output logic                      busy,
    output logic [tsc_pkg::NUM_W-1:0] quotient
);
    import tsc_pkg::*;

    logic [NUM_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] rem_next;
    logic [SPAN_W-1:0] divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [SPAN_W:0]   shifted;
    logic [SPAN_W:0]   diff;
    logic              fits;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = !diff[SPAN_W];
        rem_next = fits ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
